// ===== rtl/core/rle8_pkg.sv =====
// package: shared types and constants for the rle8 bitmap decoder
`timescale 1ns / 1ps

package rle8_pkg;

  localparam int unsigned POS_W     = 13;
  localparam int unsigned PITCH_W   = POS_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ADDR_W    = 24;

  localparam logic [POS_W-1:0] MAX_WIDTH  = POS_W'(4096);
  localparam logic [POS_W-1:0] MAX_HEIGHT = POS_W'(4096);
  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [7:0] ESC_END_LINE  = 8'd0;
  localparam logic [7:0] ESC_END_FRAME = 8'd1;
  localparam logic [7:0] ESC_DELTA     = 8'd2;

  typedef enum logic [6:0] {
    PH_PAIR1 = 7'b0000001,
    PH_PAIR2 = 7'b0000010,
    PH_DX    = 7'b0000100,
    PH_DY    = 7'b0001000,
    PH_LIT   = 7'b0010000,
    PH_PAD   = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [11:0]       out_row;
    logic [11:0]       out_column;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        pixel_value;
    logic [7:0]        pixel_count;
    logic              frame_done;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   width;
    logic [POS_W-1:0]   height;
    logic [PITCH_W-1:0] pitch;
  } cfg_t;

endpackage

// ===== rtl/core/rle8_bitmap_decoder.sv =====
// top level: rle8 bitmap decoder with input register, decode and result register
//
//   port group   direction  handshake        payload
//   in_          in         valid / stall    in_item_t  (stream_byte, frame_start)
//   out_         out        valid / stall    out_item_t (position, address, value, count, done)
//   cfg_         in         valid / ready    index, 13-bit data
//
// one item per cycle while out_stall is low; a taken item passes from the input register
// through the decode and address multiply into the result register
// synchronous active-low reset returns to start of frame, width and height 4096
// an item that produces no result still needs the result register free to move on
// out_stall holds the result register, which in turn stalls the input register
`timescale 1ns / 1ps

module rle8_bitmap_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rle8_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rle8_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rle8_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rle8_pkg::POS_W-1:0]     cfg_data
);

  rle8_pkg::cfg_t      cfg;
  rle8_pkg::in_item_t  item_r;
  rle8_pkg::out_item_t res;
  logic                item_valid_r, item_valid_nxt;
  logic                res_valid;
  logic                out_free;
  logic                advance;
  logic                accept;

  assign advance  = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  rle8_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rle8_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_go   (advance),
    .item      (item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  rle8_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .load_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .free      (out_free)
  );

endmodule

// ===== rtl/core/rle8_cfg.sv =====
// configuration registers: image width, height and derived row pitch
`timescale 1ns / 1ps

module rle8_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rle8_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rle8_pkg::POS_W-1:0]     cfg_data,
  output rle8_pkg::cfg_t                 cfg
);

  logic [rle8_pkg::POS_W-1:0]   width_r, width_nxt;
  logic [rle8_pkg::POS_W-1:0]   height_r, height_nxt;
  logic [rle8_pkg::PITCH_W-1:0] pitch_r, pitch_nxt;
  logic [rle8_pkg::PITCH_W-1:0] pitch_sum;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      if (cfg_index == rle8_pkg::REG_IMAGE_WIDTH) begin
        width_nxt = cfg_data;
      end
      if (cfg_index == rle8_pkg::REG_IMAGE_HEIGHT) begin
        height_nxt = cfg_data;
      end
    end
    // pitch rounded up to four bytes
    pitch_sum = {1'b0, width_nxt} + rle8_pkg::PITCH_W'(3);
    pitch_nxt = {pitch_sum[rle8_pkg::PITCH_W-1:2], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rle8_pkg::MAX_WIDTH;
      height_r <= rle8_pkg::MAX_HEIGHT;
      pitch_r  <= {1'b0, rle8_pkg::MAX_WIDTH};
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pitch_r  <= pitch_nxt;
    end
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign cfg.pitch  = pitch_r;

endmodule

// ===== rtl/core/rle8_decode.sv =====
// decoder state machine, position tracking and result forming
`timescale 1ns / 1ps

module rle8_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_go,
  input  rle8_pkg::in_item_t  item,
  input  rle8_pkg::cfg_t      cfg,
  output logic                res_valid,
  output rle8_pkg::out_item_t res
);

  localparam int unsigned PW = rle8_pkg::POS_W;
  localparam int unsigned MW = PW + rle8_pkg::PITCH_W;

  rle8_pkg::phase_t phase_r, phase_nxt, e_phase;
  logic [7:0]    held_r, held_nxt, e_held;
  logic [PW-1:0] col_r, col_nxt, e_col;
  logic [PW-1:0] row_r, row_nxt, e_row;
  logic [7:0]    lit_r, lit_nxt, e_lit, lit_dec;
  logic          pad_r, pad_nxt, e_pad;

  logic [7:0]    b;
  logic [PW-1:0] room;
  logic [7:0]    run_n;
  logic          lit_n;
  logic [PW:0]   row_inc_s, row_dy_s, col_dx_s;
  logic [PW-1:0] row_inc, row_dy, col_dx;
  logic [PW-1:0] pos_row, pos_col;
  logic [MW-1:0] addr_full;
  logic          hit_height;
  logic [7:0]    val;
  logic [7:0]    cnt;
  logic          done;

  always_comb begin
    b       = item.stream_byte;
    e_phase = item.frame_start ? rle8_pkg::PH_PAIR1 : phase_r;
    e_held  = item.frame_start ? 8'd0 : held_r;
    e_col   = item.frame_start ? '0 : col_r;
    e_row   = item.frame_start ? '0 : row_r;
    e_lit   = item.frame_start ? 8'd0 : lit_r;
    e_pad   = item.frame_start ? 1'b0 : pad_r;

    room  = (e_col < cfg.width) ? (cfg.width - e_col) : '0;
    run_n = (room > {{(PW-8){1'b0}}, e_held}) ? e_held : room[7:0];
    lit_n = (room != '0);
    lit_dec = e_lit - 8'd1;

    row_inc_s = {1'b0, e_row} + (PW+1)'(1);
    row_dy_s  = {1'b0, e_row} + {{(PW-7){1'b0}}, b};
    col_dx_s  = {1'b0, e_col} + {{(PW-7){1'b0}}, b};
    row_inc   = (row_inc_s > {1'b0, rle8_pkg::POS_MAX}) ? rle8_pkg::POS_MAX : row_inc_s[PW-1:0];
    row_dy    = (row_dy_s > {1'b0, rle8_pkg::POS_MAX}) ? rle8_pkg::POS_MAX : row_dy_s[PW-1:0];
    col_dx    = (col_dx_s > {1'b0, rle8_pkg::POS_MAX}) ? rle8_pkg::POS_MAX : col_dx_s[PW-1:0];

    phase_nxt = e_phase;
    held_nxt  = e_held;
    col_nxt   = e_col;
    row_nxt   = e_row;
    lit_nxt   = e_lit;
    pad_nxt   = e_pad;
    res_valid = 1'b0;
    val       = 8'd0;
    cnt       = 8'd0;
    done      = 1'b0;
    pos_row   = e_row;
    pos_col   = e_col;

    // position reported after end of line or delta is the updated one
    if (e_phase == rle8_pkg::PH_PAIR2 && e_held == 8'd0 && b == rle8_pkg::ESC_END_LINE) begin
      pos_row = row_inc;
      pos_col = '0;
    end else if (e_phase == rle8_pkg::PH_DY) begin
      pos_row = row_dy;
    end
    hit_height = (pos_row >= cfg.height);

    unique case (e_phase)
      rle8_pkg::PH_PAIR1: begin
        if (hit_height) begin
          phase_nxt = rle8_pkg::PH_DONE;
          res_valid = 1'b1;
          done      = 1'b1;
        end else begin
          held_nxt  = b;
          phase_nxt = rle8_pkg::PH_PAIR2;
        end
      end
      rle8_pkg::PH_PAIR2: begin
        if (e_held != 8'd0) begin
          res_valid = 1'b1;
          val       = b;
          cnt       = run_n;
          col_nxt   = e_col + {{(PW-8){1'b0}}, run_n};
          phase_nxt = rle8_pkg::PH_PAIR1;
        end else begin
          case (b)
            rle8_pkg::ESC_END_LINE: begin
              col_nxt = '0;
              row_nxt = row_inc;
              if (hit_height) begin
                phase_nxt = rle8_pkg::PH_DONE;
                res_valid = 1'b1;
                done      = 1'b1;
              end else begin
                phase_nxt = rle8_pkg::PH_PAIR1;
              end
            end
            rle8_pkg::ESC_END_FRAME: begin
              phase_nxt = rle8_pkg::PH_DONE;
              res_valid = 1'b1;
              done      = 1'b1;
            end
            rle8_pkg::ESC_DELTA: begin
              phase_nxt = rle8_pkg::PH_DX;
            end
            default: begin
              lit_nxt   = b;
              pad_nxt   = b[0];
              phase_nxt = rle8_pkg::PH_LIT;
            end
          endcase
        end
      end
      rle8_pkg::PH_DX: begin
        col_nxt   = col_dx;
        phase_nxt = rle8_pkg::PH_DY;
      end
      rle8_pkg::PH_DY: begin
        row_nxt = row_dy;
        if (hit_height) begin
          phase_nxt = rle8_pkg::PH_DONE;
          res_valid = 1'b1;
          done      = 1'b1;
        end else begin
          phase_nxt = rle8_pkg::PH_PAIR1;
        end
      end
      rle8_pkg::PH_LIT: begin
        res_valid = 1'b1;
        val       = b;
        cnt       = {7'd0, lit_n};
        col_nxt   = e_col + {{(PW-1){1'b0}}, lit_n};
        lit_nxt   = lit_dec;
        if (lit_dec == 8'd0) begin
          phase_nxt = e_pad ? rle8_pkg::PH_PAD : rle8_pkg::PH_PAIR1;
        end
      end
      rle8_pkg::PH_PAD: begin
        pad_nxt   = 1'b0;
        phase_nxt = rle8_pkg::PH_PAIR1;
      end
      rle8_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    addr_full = MW'(pos_row) * MW'(cfg.pitch) + MW'(pos_col);

    res.out_row      = pos_row[11:0];
    res.out_column   = pos_col[11:0];
    res.byte_address = addr_full[rle8_pkg::ADDR_W-1:0];
    res.pixel_value  = val;
    res.pixel_count  = cnt;
    res.frame_done   = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rle8_pkg::PH_PAIR1;
      held_r  <= 8'd0;
      col_r   <= '0;
      row_r   <= '0;
      lit_r   <= 8'd0;
      pad_r   <= 1'b0;
    end else if (item_go) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      lit_r   <= lit_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

// ===== rtl/core/rle8_out_reg.sv =====
// result register with valid/stall handshake
`timescale 1ns / 1ps

module rle8_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rle8_pkg::out_item_t load_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rle8_pkg::out_item_t out_data,
  output logic                free
);

  logic                valid_r, valid_nxt;
  rle8_pkg::out_item_t data_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== tb/tb_rle8_bitmap_decoder.sv =====
// testbench: rle8 bitmap decoder, directed codes and random frames checked against a predictor
`timescale 1ns / 1ps

module tb_rle8_bitmap_decoder;

  localparam int unsigned PW = rle8_pkg::POS_W;
  localparam int unsigned IW = rle8_pkg::CFG_IDX_W;

  localparam logic [7:0]    ESC_MARK     = 8'd0;
  localparam logic [IW-1:0] REG_SPARE_LO = IW'(2);
  localparam logic [IW-1:0] REG_SPARE_HI = IW'(3);

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rle8_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rle8_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IW-1:0]       cfg_index = '0;
  logic [PW-1:0]       cfg_data = '0;

  rle8_bitmap_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted decoder state
  logic [PW-1:0]    img_width;
  logic [PW-1:0]    img_height;
  rle8_pkg::phase_t dec_phase;
  logic [7:0]       run_count;
  logic [7:0]       lit_left;
  logic             pad_due;
  logic [PW-1:0]    col;
  logic [PW-1:0]    row;

  rle8_pkg::out_item_t pending_writes[$];
  int unsigned mismatches = 0;
  int unsigned accepted_items = 0;
  bit          in_idle_on = 1'b0;
  bit          out_idle_on = 1'b0;
  bit          restart_due = 1'b0;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_position();
    dec_phase = rle8_pkg::PH_PAIR1;
    run_count = '0;
    lit_left  = '0;
    pad_due   = 1'b0;
    col       = '0;
    row       = '0;
  endfunction

  function automatic logic [PW-1:0] sat_pos(logic [PW-1:0] a, logic [7:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {{(PW-7){1'b0}}, b};
    return (s > {1'b0, rle8_pkg::POS_MAX}) ? rle8_pkg::POS_MAX : s[PW-1:0];
  endfunction

  function automatic rle8_pkg::out_item_t make_write(logic [7:0] value, logic [7:0] count,
                                                     logic done);
    logic [rle8_pkg::PITCH_W-1:0] pitch;
    logic [39:0]                  addr;
    rle8_pkg::out_item_t          r;
    pitch = ({1'b0, img_width} + rle8_pkg::PITCH_W'(3)) & ~rle8_pkg::PITCH_W'(3);
    addr  = 40'(row) * 40'(pitch) + 40'(col);
    r.out_row      = row[11:0];
    r.out_column   = col[11:0];
    r.byte_address = addr[rle8_pkg::ADDR_W-1:0];
    r.pixel_value  = value;
    r.pixel_count  = count;
    r.frame_done   = done;
    return r;
  endfunction

  function automatic bit row_limit_hit(output rle8_pkg::out_item_t res);
    res = '0;
    if (row >= img_height) begin
      dec_phase = rle8_pkg::PH_DONE;
      res = make_write(8'd0, 8'd0, 1'b1);
      return 1'b1;
    end
    dec_phase = rle8_pkg::PH_PAIR1;
    return 1'b0;
  endfunction

  function automatic bit decode_byte(input rle8_pkg::in_item_t it,
                                     output rle8_pkg::out_item_t res);
    logic [7:0]    b;
    logic [7:0]    n;
    logic [PW-1:0] room;
    bit            got;
    b   = it.stream_byte;
    got = 1'b0;
    res = '0;
    if (it.frame_start)
      clear_position();
    room = (col < img_width) ? img_width - col : '0;
    case (dec_phase)
      rle8_pkg::PH_PAIR1: begin
        if (row >= img_height) begin
          dec_phase = rle8_pkg::PH_DONE;
          res = make_write(8'd0, 8'd0, 1'b1);
          got = 1'b1;
        end else begin
          run_count = b;
          dec_phase = rle8_pkg::PH_PAIR2;
        end
      end
      rle8_pkg::PH_PAIR2: begin
        if (run_count != 8'd0) begin
          n = (room > {{(PW-8){1'b0}}, run_count}) ? run_count : room[7:0];
          res = make_write(b, n, 1'b0);
          col = col + {{(PW-8){1'b0}}, n};
          dec_phase = rle8_pkg::PH_PAIR1;
          got = 1'b1;
        end else if (b == rle8_pkg::ESC_END_LINE) begin
          col = '0;
          row = sat_pos(row, 8'd1);
          got = row_limit_hit(res);
        end else if (b == rle8_pkg::ESC_END_FRAME) begin
          dec_phase = rle8_pkg::PH_DONE;
          res = make_write(8'd0, 8'd0, 1'b1);
          got = 1'b1;
        end else if (b == rle8_pkg::ESC_DELTA) begin
          dec_phase = rle8_pkg::PH_DX;
        end else begin
          lit_left  = b;
          pad_due   = b[0];
          dec_phase = rle8_pkg::PH_LIT;
        end
      end
      rle8_pkg::PH_DX: begin
        col = sat_pos(col, b);
        dec_phase = rle8_pkg::PH_DY;
      end
      rle8_pkg::PH_DY: begin
        row = sat_pos(row, b);
        got = row_limit_hit(res);
      end
      rle8_pkg::PH_LIT: begin
        n = (room != '0) ? 8'd1 : 8'd0;
        res = make_write(b, n, 1'b0);
        col = col + {{(PW-8){1'b0}}, n};
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0)
          dec_phase = pad_due ? rle8_pkg::PH_PAD : rle8_pkg::PH_PAIR1;
        got = 1'b1;
      end
      rle8_pkg::PH_PAD: begin
        pad_due = 1'b0;
        dec_phase = rle8_pkg::PH_PAIR1;
      end
      default: ;
    endcase
    return got;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s %0h, want %0h", name, got, want));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fs = 1'b0);
    rle8_pkg::in_item_t  it;
    rle8_pkg::out_item_t res;
    int unsigned         gap;
    it.stream_byte = b;
    it.frame_start = fs;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!(dec_phase == rle8_pkg::PH_DONE && !fs))
      accepted_items++;
    if (decode_byte(it, res))
      pending_writes.push_back(res);
    if (in_idle_on && $urandom_range(0, 2) == 0) begin
      gap = idle_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [PW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rle8_pkg::REG_IMAGE_WIDTH)
      img_width = val;
    else if (idx == rle8_pkg::REG_IMAGE_HEIGHT)
      img_height = val;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    rle8_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        flag_mismatch("result with nothing pending");
      end else begin
        want = pending_writes.pop_front();
        check_field("row", 32'(out_data.out_row), 32'(want.out_row));
        check_field("column", 32'(out_data.out_column), 32'(want.out_column));
        check_field("address", 32'(out_data.byte_address), 32'(want.byte_address));
        check_field("value", 32'(out_data.pixel_value), 32'(want.pixel_value));
        check_field("count", 32'(out_data.pixel_count), 32'(want.pixel_count));
        check_field("frame_done", 32'(out_data.frame_done), 32'(want.frame_done));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (out_idle_on && $urandom_range(0, 4) == 0)
      stall_left = int'(idle_len());
    out_stall <= (stall_left > 0);
  end

  task automatic test_codes_at_reset();
    send_byte(8'd255, 1'b1);
    send_byte(8'hFF);
    send_byte(8'd1);
    send_byte(8'h00);
    send_byte(ESC_MARK);
    send_byte(8'd3);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'hEE);
    send_byte(ESC_MARK);
    send_byte(rle8_pkg::ESC_END_LINE);
    send_byte(ESC_MARK);
    send_byte(rle8_pkg::ESC_DELTA);
    send_byte(8'd255);
    send_byte(8'd255);
    send_byte(ESC_MARK);
    send_byte(rle8_pkg::ESC_END_FRAME);
    send_byte(8'h5A);
  endtask

  task automatic test_clip_and_height();
    drain_results();
    write_reg(rle8_pkg::REG_IMAGE_WIDTH, PW'(5));
    write_reg(rle8_pkg::REG_IMAGE_HEIGHT, PW'(2));
    send_byte(8'd9, 1'b1);
    send_byte(8'hAA);
    send_byte(8'd3);
    send_byte(8'hBB);
    send_byte(ESC_MARK);
    send_byte(rle8_pkg::ESC_END_LINE);
    send_byte(ESC_MARK);
    send_byte(rle8_pkg::ESC_DELTA);
    send_byte(8'd0);
    send_byte(8'd1);
  endtask

  task automatic test_zero_size();
    drain_results();
    write_reg(rle8_pkg::REG_IMAGE_WIDTH, '0);
    write_reg(rle8_pkg::REG_IMAGE_HEIGHT, '0);
    send_byte(8'h10, 1'b1);
    drain_results();
    write_reg(rle8_pkg::REG_IMAGE_HEIGHT, PW'(3));
    write_reg(REG_SPARE_LO, rle8_pkg::POS_MAX);
    write_reg(REG_SPARE_HI, PW'(1));
    send_byte(8'd4, 1'b1);
    send_byte(8'h07);
  endtask

  task automatic send_random_op();
    int unsigned pick;
    int unsigned len;
    logic        fs;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      return;
    end
    fs = (dec_phase == rle8_pkg::PH_DONE) || restart_due || ($urandom_range(0, 99) == 0);
    restart_due = 1'b0;
    if (!fs && dec_phase != rle8_pkg::PH_PAIR1) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 40) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
      send_byte(8'(len), fs);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 62) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
      send_byte(ESC_MARK, fs);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      if (len[0])
        send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 78) begin
      send_byte(ESC_MARK, fs);
      send_byte(rle8_pkg::ESC_END_LINE);
    end else if (pick < 90) begin
      send_byte(ESC_MARK, fs);
      send_byte(rle8_pkg::ESC_DELTA);
      send_byte(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8)));
      send_byte(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2)));
    end else if (pick < 94) begin
      send_byte(ESC_MARK, fs);
      send_byte(rle8_pkg::ESC_END_FRAME);
    end else begin
      // literal cut short by a new frame
      send_byte(ESC_MARK, fs);
      send_byte(8'($urandom_range(3, 40)));
      send_byte(8'($urandom_range(0, 255)));
      restart_due = 1'b1;
    end
  endtask

  task automatic test_random_frames(input int unsigned item_goal);
    int unsigned goal;
    for (int p = 0; p < 6; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(rle8_pkg::REG_IMAGE_WIDTH, rle8_pkg::POS_MAX);
          write_reg(rle8_pkg::REG_IMAGE_HEIGHT, rle8_pkg::POS_MAX);
        end
        1: begin
          write_reg(rle8_pkg::REG_IMAGE_WIDTH, PW'(1));
          write_reg(rle8_pkg::REG_IMAGE_HEIGHT, PW'(1));
        end
        2: begin
          write_reg(rle8_pkg::REG_IMAGE_WIDTH, PW'($urandom_range(1, 64)));
          write_reg(rle8_pkg::REG_IMAGE_HEIGHT, PW'($urandom_range(1, 8)));
        end
        3: begin
          write_reg(rle8_pkg::REG_IMAGE_WIDTH, PW'($urandom_range(1, 4096)));
          write_reg(rle8_pkg::REG_IMAGE_HEIGHT, PW'($urandom_range(1, 4096)));
        end
        4: begin
          write_reg(rle8_pkg::REG_IMAGE_WIDTH, '0);
          write_reg(rle8_pkg::REG_IMAGE_HEIGHT, PW'($urandom_range(1, 16)));
          write_reg(REG_SPARE_LO, PW'($urandom_range(0, 8191)));
        end
        default: begin
          write_reg(rle8_pkg::REG_IMAGE_WIDTH, PW'($urandom_range(0, 8191)));
          write_reg(rle8_pkg::REG_IMAGE_HEIGHT, PW'($urandom_range(0, 8191)));
          write_reg(REG_SPARE_HI, PW'($urandom_range(0, 8191)));
        end
      endcase
      in_idle_on  = (p % 3 != 1);
      out_idle_on = (p % 3 != 1);
      goal = accepted_items + item_goal / 6;
      while (accepted_items < goal)
        send_random_op();
    end
  endtask

  initial begin
    img_width  = rle8_pkg::MAX_WIDTH;
    img_height = rle8_pkg::MAX_HEIGHT;
    clear_position();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    test_codes_at_reset();
    test_clip_and_height();
    test_zero_size();
    test_random_frames(700);
    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
